>>> design/cdsc_pkg.sv
// Shared types and codes for the card deck stream cipher.
package cdsc_pkg;

    typedef enum logic [1:0] {
        ACT_IDENTITY = 2'd0,
        ACT_LOAD     = 2'd1,
        ACT_ENCRYPT  = 2'd2,
        ACT_DECRYPT  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_RANGE      = 2'd1,
        ST_REPEATED   = 2'd2,
        ST_INCOMPLETE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_RDPOS,
        S_LD_RDDECK,
        S_LD_CHK,
        S_NZ_TAG,
        S_NZ_PREV,
        S_NZ_AT,
        S_NZ_CARD,
        S_SHUF,
        S_CUTRD,
        S_CUTWAIT,
        S_CUT,
        S_DONE
    } t_state;

    // Deck position that selects the noise card.
    localparam int unsigned TagPos = 2;

    localparam int unsigned SymW = 6;

endpackage

>>> design/card_deck_stream_cipher_top.sv
// Top level of the card deck stream cipher: sequencer around deck and position memories.
//
// The block keeps a permuted deck of DECK_SIZE cards in one memory and the
// inverse (position of each card) in a second memory; both are synchronous,
// one read and one write per cycle, with registered read data. An item
// is one transfer on the slave stream: tuser selects the action (identity,
// load card, encrypt, decrypt) and carries the first-card flag, tdata the
// symbol. Every item returns exactly one transfer on the master stream with
// the result symbol and a status. Items are worked one at a time. Identity
// goes straight to the result register. A card load reads the card's
// position and, if that is below the load pointer, the deck entry there to
// find a repeat; a rejected card or an ignored load reads nothing. Encrypt
// or decrypt: three reads and a modular sum find the noise card, then one
// pass over the deck memory shuffles into the position memory and a second
// pass over the position memory applies the cut and rewrites both memories.
// The memory passes set the rate. Once the result is registered the block
// is idle again for the next item. A finished result sits in an output
// register so the next item can be taken while it waits. Reset and the
// identity action clear per-entry valid bits at once; an entry not yet
// written reads as the identity, so no clearing pass is needed.
module card_deck_stream_cipher_top
    import cdsc_pkg::*;
#(
    parameter int unsigned DECK_SIZE = 40
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [5:0] symbol
    input  logic [2:0] i_s_tuser,   // [1:0] action, [2] first
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [5:0] result_symbol
    output logic [1:0] o_m_tuser    // [1:0] status
);

    localparam int unsigned AW   = $clog2(DECK_SIZE);
    localparam int unsigned LW   = $clog2(DECK_SIZE + 1);
    localparam int unsigned Half = DECK_SIZE / 2;

    // Deck and inverse memories with valid bits.
    logic [AW-1:0]        r_deck_mem [DECK_SIZE];
    logic [AW-1:0]        r_pos_mem  [DECK_SIZE];
    logic [DECK_SIZE-1:0] r_deck_vld, n_deck_vld;
    logic [DECK_SIZE-1:0] r_pos_vld, n_pos_vld;

    logic          a_re, a_we, b_re, b_we;
    logic [AW-1:0] a_raddr, a_waddr, a_wdata, b_raddr, b_waddr, b_wdata;
    logic [AW-1:0] r_a_q, r_a_addr, r_b_q, r_b_addr;
    logic          r_a_hit, r_b_hit, r_a_rv, r_b_rv;
    logic [AW-1:0] a_rdata, b_rdata;

    t_state        r_state, n_state;
    logic [LW-1:0] r_lp, n_lp;
    logic          r_ab, n_ab;
    logic [AW-1:0] r_sym, n_sym;
    logic          r_enc, n_enc;
    logic [AW-1:0] r_clear, n_clear;
    logic [AW-1:0] r_top, n_top;
    logic [AW-1:0] r_cut, n_cut;
    logic [LW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_res, n_res;
    t_status       r_stat, n_stat;
    logic          r_ov, n_ov;
    logic [SymW-1:0] r_od, n_od;
    t_status       r_os, n_os;

    logic [SymW-1:0] in_sym;
    t_action         in_act;
    logic            in_first;
    logic [9:0]      sym_mod;
    logic [AW:0]     sum_w;
    logic [AW-1:0]   dst, newpos;
    logic [LW-1:0]   lp_eff;
    logic            ab_eff;

    assign in_sym   = i_s_tdata[SymW-1:0];
    assign in_act   = t_action'(i_s_tuser[1:0]);
    assign in_first = i_s_tuser[2];

    assign a_rdata = r_a_hit ? r_a_q : r_a_addr;
    assign b_rdata = r_b_hit ? r_b_q : r_b_addr;

    // Reduce the incoming symbol by subtracting scaled deck sizes.
    always_comb begin
        sym_mod = {4'd0, in_sym};
        for (int k = 4; k >= 0; k--) begin
            if (sym_mod >= 10'(DECK_SIZE << k)) begin
                sym_mod = sym_mod - 10'(DECK_SIZE << k);
            end
        end
    end

    // Shuffle destination of the card just read, and cut position.
    assign dst = r_a_addr[0] ? AW'(Half - 1 - (r_a_addr >> 1)) : AW'(Half + (r_a_addr >> 1));
    assign newpos = (b_rdata >= r_cut) ? AW'(b_rdata - r_cut)
                                       : AW'((AW+1)'(b_rdata) + (AW+1)'(DECK_SIZE) - r_cut);

    assign lp_eff = in_first ? '0 : r_lp;
    assign ab_eff = in_first ? 1'b0 : r_ab;

    always_comb begin
        n_state = r_state;
        n_lp = r_lp; n_ab = r_ab; n_sym = r_sym; n_enc = r_enc;
        n_clear = r_clear; n_top = r_top; n_cut = r_cut; n_cnt = r_cnt;
        n_res = r_res; n_stat = r_stat;
        n_deck_vld = r_deck_vld; n_pos_vld = r_pos_vld;
        a_re = 1'b0; a_raddr = '0; a_we = 1'b0; a_waddr = '0; a_wdata = '0;
        b_re = 1'b0; b_raddr = '0; b_we = 1'b0; b_waddr = '0; b_wdata = '0;
        sum_w = '0;
        o_s_tready = 1'b0;
        n_ov = r_ov && !i_m_tready;
        n_od = r_od; n_os = r_os;

        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_res  = '0;
                    n_stat = ST_OK;
                    n_state = S_DONE;
                    n_sym  = sym_mod[AW-1:0];
                    n_enc  = (in_act == ACT_ENCRYPT);
                    unique case (in_act)
                        ACT_IDENTITY: begin
                            n_deck_vld = '0;
                            n_pos_vld  = '0;
                            n_lp = LW'(DECK_SIZE);
                            n_ab = 1'b0;
                        end
                        ACT_LOAD: begin
                            n_lp = lp_eff;
                            n_ab = ab_eff;
                            if (ab_eff) begin
                                n_stat = ST_INCOMPLETE;
                            end else if (lp_eff < LW'(DECK_SIZE)) begin
                                if (in_sym >= SymW'(DECK_SIZE)) begin
                                    n_stat = ST_RANGE;
                                    n_ab   = 1'b1;
                                end else begin
                                    n_sym   = in_sym[AW-1:0];
                                    n_state = S_LD_RDPOS;
                                end
                            end
                        end
                        ACT_ENCRYPT, ACT_DECRYPT: begin
                            if (r_lp < LW'(DECK_SIZE)) begin
                                n_stat = ST_INCOMPLETE;
                            end else begin
                                n_state = S_NZ_TAG;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LD_RDPOS: begin
                b_re = 1'b1; b_raddr = r_sym;
                n_state = S_LD_RDDECK;
            end
            S_LD_RDDECK: begin
                if (LW'(b_rdata) < r_lp) begin
                    a_re = 1'b1; a_raddr = b_rdata;
                    n_state = S_LD_CHK;
                end else begin
                    a_we = 1'b1; a_waddr = r_lp[AW-1:0]; a_wdata = r_sym;
                    b_we = 1'b1; b_waddr = r_sym; b_wdata = r_lp[AW-1:0];
                    n_lp = r_lp + 1'b1;
                    n_state = S_DONE;
                end
            end
            S_LD_CHK: begin
                if (a_rdata == r_sym) begin
                    n_stat = ST_REPEATED;
                    n_ab   = 1'b1;
                end else begin
                    a_we = 1'b1; a_waddr = r_lp[AW-1:0]; a_wdata = r_sym;
                    b_we = 1'b1; b_waddr = r_sym; b_wdata = r_lp[AW-1:0];
                    n_lp = r_lp + 1'b1;
                end
                n_state = S_DONE;
            end
            S_NZ_TAG: begin
                a_re = 1'b1; a_raddr = AW'(TagPos);
                n_state = S_NZ_PREV;
            end
            S_NZ_PREV: begin
                b_re = 1'b1;
                b_raddr = (a_rdata == '0) ? AW'(DECK_SIZE - 1) : a_rdata - 1'b1;
                n_state = S_NZ_AT;
            end
            S_NZ_AT: begin
                a_re = 1'b1;
                a_raddr = (b_rdata == AW'(DECK_SIZE - 1)) ? '0 : b_rdata + 1'b1;
                n_state = S_NZ_CARD;
            end
            S_NZ_CARD: begin
                // a_rdata is the noise card
                if (r_enc) begin
                    sum_w = (AW+1)'(r_sym) + (AW+1)'(a_rdata);
                    if (sum_w >= (AW+1)'(DECK_SIZE)) sum_w = sum_w - (AW+1)'(DECK_SIZE);
                    n_res   = sum_w[AW-1:0];
                    n_clear = r_sym;
                end else begin
                    sum_w = (r_sym >= a_rdata) ? (AW+1)'(r_sym - a_rdata)
                          : (AW+1)'(r_sym) + (AW+1)'(DECK_SIZE) - (AW+1)'(a_rdata);
                    n_res   = sum_w[AW-1:0];
                    n_clear = sum_w[AW-1:0];
                end
                n_cnt = '0;
                n_state = S_SHUF;
            end
            S_SHUF: begin
                if (r_cnt != LW'(DECK_SIZE)) begin
                    a_re = 1'b1; a_raddr = r_cnt[AW-1:0];
                    n_cnt = r_cnt + 1'b1;
                end
                if (r_a_rv) begin
                    b_we = 1'b1; b_waddr = a_rdata; b_wdata = dst;
                    if (r_a_addr == AW'(2 * Half - 1)) n_top = a_rdata;
                    if (r_a_addr == AW'(DECK_SIZE - 1)) n_state = S_CUTRD;
                end
            end
            S_CUTRD: begin
                sum_w = (AW+1)'(r_clear) + (AW+1)'(r_top);
                if (sum_w >= (AW+1)'(DECK_SIZE)) sum_w = sum_w - (AW+1)'(DECK_SIZE);
                b_re = 1'b1; b_raddr = sum_w[AW-1:0];
                n_state = S_CUTWAIT;
            end
            S_CUTWAIT: begin
                n_cut = b_rdata;
                n_cnt = '0;
                n_state = S_CUT;
            end
            S_CUT: begin
                if (r_cnt != LW'(DECK_SIZE)) begin
                    b_re = 1'b1; b_raddr = r_cnt[AW-1:0];
                    n_cnt = r_cnt + 1'b1;
                end
                if (r_b_rv) begin
                    b_we = 1'b1; b_waddr = r_b_addr; b_wdata = newpos;
                    a_we = 1'b1; a_waddr = newpos;   a_wdata = r_b_addr;
                    if (r_b_addr == AW'(DECK_SIZE - 1)) n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ov || i_m_tready) begin
                    n_ov = 1'b1;
                    n_od = SymW'(r_res);
                    n_os = r_stat;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (a_we) n_deck_vld[a_waddr] = 1'b1;
        if (b_we) n_pos_vld[b_waddr]  = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_lp       <= LW'(DECK_SIZE);
            r_ab       <= 1'b0;
            r_deck_vld <= '0;
            r_pos_vld  <= '0;
            r_ov       <= 1'b0;
            r_a_rv     <= 1'b0;
            r_b_rv     <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_lp       <= n_lp;
            r_ab       <= n_ab;
            r_deck_vld <= n_deck_vld;
            r_pos_vld  <= n_pos_vld;
            r_ov       <= n_ov;
            r_a_rv     <= a_re;
            r_b_rv     <= b_re;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym <= n_sym; r_enc <= n_enc; r_clear <= n_clear;
        r_top <= n_top; r_cut <= n_cut; r_res <= n_res; r_stat <= n_stat;
        r_od  <= n_od;  r_os  <= n_os;
    end

    // Deck memory: one read, one write.
    always_ff @(posedge i_clk) begin
        if (a_we) r_deck_mem[a_waddr] <= a_wdata;
        if (a_re) begin
            r_a_q    <= r_deck_mem[a_raddr];
            r_a_hit  <= r_deck_vld[a_raddr];
            r_a_addr <= a_raddr;
        end
    end

    // Position memory: one read, one write.
    always_ff @(posedge i_clk) begin
        if (b_we) r_pos_mem[b_waddr] <= b_wdata;
        if (b_re) begin
            r_b_q    <= r_pos_mem[b_raddr];
            r_b_hit  <= r_pos_vld[b_raddr];
            r_b_addr <= b_raddr;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {2'b00, r_od};
    assign o_m_tuser  = r_os;

    // The load pointer never runs past the deck.
    a_lp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lp <= LW'(DECK_SIZE))
        else $error("load pointer beyond deck");

    // Cipher passes only run on a complete deck.
    a_cipher_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHUF || r_state == S_CUT) |-> r_lp == LW'(DECK_SIZE))
        else $error("cipher on incomplete deck");

    // The two memories are never written at an address outside the deck.
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_we || b_we) |-> (a_waddr < AW'(DECK_SIZE) && b_waddr < AW'(DECK_SIZE)))
        else $error("memory write out of range");

    // A held result is only replaced after it has been taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_m_tready) |=> (r_ov && $stable(r_od) && $stable(r_os)))
        else $error("pending result overwritten");

endmodule

>>> tb/card_deck_stream_cipher_top_tb.sv
// Self-checking testbench for the card deck stream cipher top level.
`timescale 1ns / 100ps

module card_deck_stream_cipher_top_tb;
    import cdsc_pkg::*;

    localparam int unsigned DECK = 40;

    typedef struct packed {
        logic [5:0] sym;
        t_status    status;
    } t_cipher_out;

    typedef struct {
        t_action    act;
        logic [5:0] sym;
        logic       first;
        logic       has_exp;
        logic [5:0] exp_sym;
        t_status    exp_status;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;   // [5:0] symbol
    logic [2:0] i_s_tuser;   // [1:0] action, [2] first
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;   // [5:0] result_symbol
    logic [1:0] o_m_tuser;   // [1:0] status

    card_deck_stream_cipher_top #(.DECK_SIZE(DECK)) dut (.*);

    // Predictor state: deck, its inverse, load progress.
    logic [5:0]  deck_q [DECK];
    logic [5:0]  pos_q  [64];
    logic [5:0]  load_at;
    logic        load_dead;
    t_cipher_out cipher_expq [$];
    int          n_errors;
    bit          calm;   // stretch with no idling on either side

    // Set the predicted deck and its inverse back to the identity permutation.
    function automatic void deck_identity();
        for (int i = 0; i < 64; i++) pos_q[i] = '0;
        for (int i = 0; i < DECK; i++) begin
            deck_q[i] = 6'(i);
            pos_q[i]  = 6'(i);
        end
        load_at   = 6'(DECK);
        load_dead = 1'b0;
    endfunction

    function automatic void rebuild_inverse();
        for (int i = 0; i < DECK; i++) pos_q[deck_q[i]] = 6'(i);
    endfunction

    // Apply one item to the predicted deck and return its result.
    function automatic t_cipher_out cipher_predict(t_action act, logic [5:0] sym,
                                                   logic first);
        t_cipher_out r;
        logic [5:0]  tmp [DECK];
        int          s, noise, clear, half, dst, cut_card, cut_at, prev, at;
        r.sym = '0;
        r.status = ST_OK;
        half = DECK / 2;
        case (act)
            ACT_IDENTITY: deck_identity();
            ACT_LOAD: begin
                if (first) begin
                    load_at = '0;
                    load_dead = 1'b0;
                end
                if (load_dead) r.status = ST_INCOMPLETE;
                else if (load_at < DECK) begin
                    if (sym >= DECK) begin
                        r.status = ST_RANGE;
                        load_dead = 1'b1;
                    end else if (pos_q[sym] < load_at && deck_q[pos_q[sym]] == sym) begin
                        r.status = ST_REPEATED;
                        load_dead = 1'b1;
                    end else begin
                        deck_q[load_at] = sym;
                        pos_q[sym] = load_at;
                        load_at++;
                    end
                end
            end
            default: begin
                if (load_at < DECK) r.status = ST_INCOMPLETE;
                else begin
                    s = sym % DECK;
                    prev = (deck_q[TagPos] + DECK - 1) % DECK;
                    at = (pos_q[prev] + 1) % DECK;
                    noise = deck_q[at] % DECK;
                    if (act == ACT_ENCRYPT) begin
                        clear = s;
                        r.sym = 6'((s + noise) % DECK);
                    end else begin
                        clear = (s + DECK - noise) % DECK;
                        r.sym = 6'(clear);
                    end
                    // back-front shuffle
                    for (int p = 0; p < DECK; p++) begin
                        dst = (p % 2) ? half - (p + 1) / 2 : half + p / 2;
                        tmp[dst] = deck_q[p];
                    end
                    deck_q = tmp;
                    rebuild_inverse();
                    // cut at (clear + top card)
                    cut_card = (clear + deck_q[0]) % DECK;
                    cut_at = pos_q[cut_card] % DECK;
                    for (int p = 0; p < DECK; p++) tmp[p] = deck_q[(p + cut_at) % DECK];
                    deck_q = tmp;
                    rebuild_inverse();
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        n_errors++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Send one transfer: hold valid until accepted, with a random gap first.
    task automatic send_item(t_action act, logic [5:0] sym, logic first);
        while (!calm && $urandom_range(99) < 7) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, sym};
        i_s_tuser  <= {first, act};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        cipher_expq.push_back(cipher_predict(act, sym, first));
    endtask

    task automatic send_checked(t_stim_row row);
        t_cipher_out e;
        send_item(row.act, row.sym, row.first);
        if (row.has_exp) begin
            e = cipher_expq[$];
            if (e.sym != row.exp_sym) report_mismatch("table sym", e.sym, row.exp_sym);
            if (e.status != row.exp_status)
                report_mismatch("table status", e.status, row.exp_status);
        end
    endtask

    // Receiver: random stalls, compare each transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_cipher_out e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (cipher_expq.size() == 0) report_mismatch("unexpected result", o_m_tdata, 0);
            else begin
                e = cipher_expq.pop_front();
                if (o_m_tdata != {2'b00, e.sym}) report_mismatch("result_symbol", o_m_tdata, e.sym);
                if (o_m_tuser != e.status) report_mismatch("status", o_m_tuser, e.status);
            end
        end
        i_m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 7);
    end

    // Load a full permutation as a key, with random content.
    task automatic load_random_key();
        logic [5:0] perm [DECK];
        int         j;
        logic [5:0] t;
        for (int i = 0; i < DECK; i++) perm[i] = 6'(i);
        for (int i = DECK - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = perm[i]; perm[i] = perm[j]; perm[j] = t;
        end
        for (int i = 0; i < DECK; i++) send_item(ACT_LOAD, perm[i], i == 0);
    endtask

    t_stim_row dir_rows [$];
    t_action   ract;
    int        sent;

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= '0;
        i_m_tready <= 1'b0;
        calm = 1'b0;
        n_errors = 0;
        deck_identity();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: identity deck, extremes, every error status.
        dir_rows = '{
            '{ACT_ENCRYPT,  6'd0,  1'b0, 1'b0, 6'd0, ST_OK},
            '{ACT_DECRYPT,  6'd63, 1'b0, 1'b0, 6'd0, ST_OK},
            '{ACT_ENCRYPT,  6'd39, 1'b0, 1'b0, 6'd0, ST_OK},
            '{ACT_LOAD,     6'd5,  1'b0, 1'b1, 6'd0, ST_OK},
            '{ACT_LOAD,     6'd7,  1'b1, 1'b1, 6'd0, ST_OK},
            '{ACT_ENCRYPT,  6'd1,  1'b0, 1'b1, 6'd0, ST_INCOMPLETE},
            '{ACT_DECRYPT,  6'd1,  1'b0, 1'b1, 6'd0, ST_INCOMPLETE},
            '{ACT_LOAD,     6'd7,  1'b0, 1'b1, 6'd0, ST_REPEATED},
            '{ACT_LOAD,     6'd8,  1'b0, 1'b1, 6'd0, ST_INCOMPLETE},
            '{ACT_LOAD,     6'd40, 1'b1, 1'b1, 6'd0, ST_RANGE},
            '{ACT_LOAD,     6'd63, 1'b1, 1'b1, 6'd0, ST_RANGE},
            '{ACT_LOAD,     6'd0,  1'b1, 1'b1, 6'd0, ST_OK},
            '{ACT_LOAD,     6'd39, 1'b0, 1'b1, 6'd0, ST_OK},
            '{ACT_IDENTITY, 6'd63, 1'b1, 1'b1, 6'd0, ST_OK},
            '{ACT_ENCRYPT,  6'd63, 1'b1, 1'b0, 6'd0, ST_OK},
            '{ACT_DECRYPT,  6'd0,  1'b0, 1'b0, 6'd0, ST_OK},
            '{ACT_IDENTITY, 6'd0,  1'b0, 1'b1, 6'd0, ST_OK}
        };
        foreach (dir_rows[k]) send_checked(dir_rows[k]);

        // Random part: mostly full key loads followed by cipher runs, some noise.
        sent = 0;
        while (sent < 1000) begin
            calm = (sent >= 400 && sent < 550);
            case ($urandom_range(9))
                0: begin
                    send_item(t_action'($urandom_range(3)), 6'($urandom_range(63)),
                              1'($urandom_range(1)));
                    sent++;
                end
                1, 2, 3: begin
                    load_random_key();
                    sent += DECK;
                end
                default: begin
                    for (int k = $urandom_range(1, 20); k > 0; k--) begin
                        ract = $urandom_range(1) ? ACT_ENCRYPT : ACT_DECRYPT;
                        send_item(ract, 6'($urandom_range(63)), 1'($urandom_range(1)));
                        sent++;
                    end
                end
            endcase
        end
        i_s_tvalid <= 1'b0;

        // Drain, then allow the pipeline to settle.
        while (cipher_expq.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    // Hard limit on the run.
    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
design/cdsc_pkg.sv
design/card_deck_stream_cipher_top.sv
tb/card_deck_stream_cipher_top_tb.sv
